@@ hw/rtl/selt_pkg.sv @@
// selt_pkg: shared types and codes for the shared/exclusive lock table
// request modes, status codes, scan token, request and slot write structs
// no dependencies
package selt_pkg;

    localparam int SLOT_W = 4;
    localparam int OBJ_W  = 32;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;

    localparam logic [MODE_W-1:0] MODE_ACQUIRE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RESERVE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_UNRESERVE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RELOCATE = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_IN_USE  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd3;

    // token that walks the cell row, one cell per cycle
    typedef struct packed {
        logic              go;
        logic              conflict;
        logic              found;
        logic [SLOT_W-1:0] free_idx;
    } scan_t;

    // request held stable while the token walks
    typedef struct packed {
        logic             acquire;
        logic             relocate;
        logic [OBJ_W-1:0] obj;
        logic             excl;
        logic [OBJ_W-1:0] src;
        logic [OBJ_W:0]   lim;
    } req_t;

    // slot fill or free, broadcast to every cell
    typedef struct packed {
        logic              set;
        logic              clr;
        logic [SLOT_W-1:0] idx;
        logic [OBJ_W-1:0]  obj;
        logic              excl;
        logic [OBJ_W-1:0]  extent;
    } wr_t;

endpackage

@@ hw/rtl/shared_exclusive_lock_table_top.sv @@
// shared_exclusive_lock_table_top: lock table built as a row of slot cells
// depends on selt_pkg and selt_cell
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser: mode, tdata: request fields
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: status, granted_slot
// cfg       in   cfg_we (no back-pressure)      cfg_wdata: root_node
//
// acquire and relocate send a scan token through all used cells (at most 16),
// one cell per clock, then load their result into the output register
// release, reserve, unreserve and unknown modes skip the scan and go to ST_OUT
// one request in flight; the result waits in an output register under stall
// reset is asynchronous, active low; it frees all slots, clears the
// reservation and sets root_node to 1
module shared_exclusive_lock_table_top
    import selt_pkg::*;
#(
    parameter int LOCK_SLOTS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    // config
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,     // root_node
    // request stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [2:0]   s_axis_tuser,  // mode
    // object_node[31:0], exclusive[32], first_extent[64:33], lock_slot[68:65],
    // move_source[100:69], move_blocks[132:101], zero [135:133]
    input  logic [135:0] s_axis_tdata,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata   // status[1:0], granted_slot[5:2], zero [7:6]
);

    // only sixteen slots can be named by the 4-bit slot fields
    localparam int USED = (LOCK_SLOTS < 16) ? LOCK_SLOTS : 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } state_t;

    state_t              state_reg;
    logic [OBJ_W-1:0]    root_reg;
    logic [OBJ_W-1:0]    reserved_reg;
    req_t                req_reg;
    logic                start_reg;
    logic [STAT_W-1:0]   stat_reg;
    logic [SLOT_W-1:0]   grant_reg;
    logic                m_valid_reg;
    logic [7:0]          m_data_reg;

    // request fields
    logic [MODE_W-1:0]   in_mode;
    logic [OBJ_W-1:0]    in_obj;
    logic                in_excl;
    logic [OBJ_W-1:0]    in_extent;
    logic [SLOT_W-1:0]   in_slot;
    logic [OBJ_W-1:0]    in_src;
    logic [OBJ_W-1:0]    in_cnt;

    logic                accept;
    logic                scan_done;
    logic                pre_block;
    logic                grant_ok;
    logic                rel_ok;
    logic                out_free;
    logic [USED-1:0]     valid_vec;
    logic [15:0]         valid16;
    scan_t               chain [USED+1];
    scan_t               last;
    wr_t                 wr;

    assign in_mode   = s_axis_tuser;
    assign in_obj    = s_axis_tdata[31:0];
    assign in_excl   = s_axis_tdata[32];
    assign in_extent = s_axis_tdata[64:33];
    assign in_slot   = s_axis_tdata[68:65];
    assign in_src    = s_axis_tdata[100:69];
    assign in_cnt    = s_axis_tdata[132:101];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // token enters cell 0 the cycle after accept and leaves the last cell
    assign chain[0] = '{go: start_reg, conflict: 1'b0, found: 1'b0, free_idx: '0};
    assign last     = chain[USED];

    for (genvar i = 0; i < USED; i++)
    begin : g_cell
        selt_cell #(
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .req      (req_reg),
            .wr       (wr),
            .scan_in  (chain[i]),
            .scan_out (chain[i+1]),
            .valid    (valid_vec[i])
        );
    end

    // slots past the used ones read as never valid
    assign valid16 = 16'(valid_vec);

    assign scan_done = (state_reg == ST_SCAN) && last.go;
    // exclusive acquires on root or on the reserved object are refused outright
    assign pre_block = req_reg.excl && ((req_reg.obj == root_reg) || (req_reg.obj == reserved_reg));
    assign grant_ok  = scan_done && req_reg.acquire && !pre_block && !last.conflict && last.found;
    assign rel_ok    = valid16[in_slot];

    // first_extent is held apart from the scan request
    logic [OBJ_W-1:0] extent_reg;
    logic [OBJ_W-1:0] extent_next;

    assign extent_next = accept ? in_extent : extent_reg;

    always_ff @(posedge clk)
    begin
        extent_reg <= extent_next;
    end

    // fill on a granted acquire, free on a good release
    always_comb
    begin
        wr.set    = grant_ok;
        wr.clr    = accept && (in_mode == MODE_RELEASE) && rel_ok;
        wr.idx    = grant_ok ? last.free_idx : in_slot;
        wr.obj    = req_reg.obj;
        wr.excl   = req_reg.excl;
        wr.extent = extent_reg;
    end

    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            root_reg     <= 32'd1;
            reserved_reg <= '0;
            req_reg      <= '0;
            start_reg    <= 1'b0;
            stat_reg     <= STAT_OK;
            grant_reg    <= '0;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
        end
        else
        begin
            start_reg <= accept && ((in_mode == MODE_ACQUIRE) || (in_mode == MODE_RELOCATE));
            if (cfg_we)
            begin
                root_reg <= cfg_wdata;
            end
            // a new result loads while the old one leaves, so valid stays up
            if ((state_reg == ST_OUT) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg   <= '{acquire:  (in_mode == MODE_ACQUIRE),
                                       relocate: (in_mode == MODE_RELOCATE),
                                       obj:      in_obj,
                                       excl:     in_excl,
                                       src:      in_src,
                                       lim:      {1'b0, in_src} + {1'b0, in_cnt}};
                        grant_reg <= '0;
                        case (in_mode)
                            MODE_ACQUIRE, MODE_RELOCATE:
                            begin
                                stat_reg  <= STAT_OK;
                                state_reg <= ST_SCAN;
                            end
                            MODE_RELEASE:
                            begin
                                stat_reg  <= rel_ok ? STAT_OK : STAT_INVALID;
                                state_reg <= ST_OUT;
                            end
                            MODE_RESERVE:
                            begin
                                stat_reg     <= STAT_OK;
                                reserved_reg <= in_obj;
                                state_reg    <= ST_OUT;
                            end
                            MODE_UNRESERVE:
                            begin
                                stat_reg     <= STAT_OK;
                                reserved_reg <= '0;
                                state_reg    <= ST_OUT;
                            end
                            default:
                            begin
                                stat_reg  <= STAT_OK;
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (last.go)
                    begin
                        if (req_reg.acquire)
                        begin
                            if (pre_block || last.conflict)
                            begin
                                stat_reg <= STAT_IN_USE;
                            end
                            else if (!last.found)
                            begin
                                stat_reg <= STAT_FULL;
                            end
                            else
                            begin
                                grant_reg <= last.free_idx;
                            end
                        end
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_data_reg  <= {2'b00, grant_reg, stat_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

@@ hw/rtl/selt_cell.sv @@
// selt_cell: one lock slot of the row, with its own match and range compare
// depends on selt_pkg
// registers the scan token and hands it to the next cell every cycle
module selt_cell
    import selt_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  req_t  req,
    input  wr_t   wr,
    input  scan_t scan_in,
    output scan_t scan_out,
    output logic  valid
);

    logic             valid_reg;
    logic [OBJ_W-1:0] obj_reg;
    logic             excl_reg;
    logic [OBJ_W-1:0] ext_reg;
    scan_t            scan_reg;
    scan_t            scan_next;
    logic             hit_me;
    logic             in_range;
    logic             zero_ext;

    assign hit_me   = (wr.idx == SLOT_W'(IDX));
    assign in_range = (ext_reg >= req.src) && ({1'b0, ext_reg} < req.lim);
    assign zero_ext = scan_in.go && req.relocate && valid_reg && in_range;

    always_comb
    begin
        scan_next = scan_in;
        if (scan_in.go && req.acquire)
        begin
            if (valid_reg && (obj_reg == req.obj) && (excl_reg || req.excl))
            begin
                scan_next.conflict = 1'b1;
            end
            if (!valid_reg && !scan_in.found)
            begin
                scan_next.found    = 1'b1;
                scan_next.free_idx = SLOT_W'(IDX);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            scan_reg  <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
            if (wr.set && hit_me)
            begin
                valid_reg <= 1'b1;
            end
            else if (wr.clr && hit_me)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (wr.set && hit_me)
        begin
            obj_reg  <= wr.obj;
            excl_reg <= wr.excl;
            ext_reg  <= wr.extent;
        end
        else if (zero_ext)
        begin
            ext_reg <= '0;
        end
    end

    assign scan_out = scan_reg;
    assign valid    = valid_reg;

endmodule

@@ hw/rtl/selt_checker.sv @@
// selt_checker: port-level checks on the lock table top
// depends on selt_pkg; bound to shared_exclusive_lock_table_top below
module selt_checker
    import selt_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [7:0]   m_axis_tdata
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped under stall");

    // one request at a time: no accept right after an accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while one is in flight");

    // a result with a failing status carries slot zero
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != STAT_OK) |-> (m_axis_tdata[5:2] == 4'd0))
        else $error("slot reported with failing status");

    // a result never shows up the cycle after its request is taken
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result too early");

endmodule

bind shared_exclusive_lock_table_top selt_checker u_selt_checker (.*);
